[rtl/adm_pkg.sv]
`timescale 1ns / 1ps

package adm_pkg;

  // stick full scale, the divisor of the limit scaling
  localparam int FULL_SCALE = 127;

  // field widths
  localparam int STICK_W = 8;
  localparam int SPD_W   = 11;
  localparam int OUT_W   = 8;
  localparam int CFG_W   = 7;
  localparam int MAG_W   = 8;   // stick magnitudes and limits, up to 255

  // shared multiplier operand widths
  localparam int A_W = 17;
  localparam int B_W = 19;
  localparam int P_W = A_W + B_W;

  // signed Q8 power word
  localparam int V_W = 19;

  // divide by full scale as multiply by rounded-up reciprocal, exact below 2^16
  localparam int RECIP_SH = 24;
  localparam logic [B_W-1:0] RECIP = B_W'((2**RECIP_SH + FULL_SCALE - 1) / FULL_SCALE);

  // Q8 factors
  localparam logic [B_W-1:0] Q_ONE = B_W'(256);
  localparam logic [B_W-1:0] Q_085 = B_W'(218);
  localparam logic [B_W-1:0] Q_090 = B_W'(230);
  localparam logic [B_W-1:0] Q_095 = B_W'(243);
  localparam logic [B_W-1:0] Q_080 = B_W'(205);
  localparam logic [B_W-1:0] Q_070 = B_W'(179);

  // zone and deadband thresholds
  localparam logic [MAG_W-1:0] ZONE_HI  = MAG_W'(123);
  localparam logic [MAG_W-1:0] ZONE_LO  = MAG_W'(110);
  localparam logic [MAG_W-1:0] DEADBAND = MAG_W'(20);
  // |left - right| < 25 means twice the turn magnitude below 25
  localparam logic [MAG_W-1:0] STALL_TURN_MAX = MAG_W'(12);

  // stall cut levels in Q8
  localparam logic signed [V_W-1:0] V_25 = V_W'(25 * 256);
  localparam logic signed [V_W-1:0] V_45 = V_W'(45 * 256);
  localparam logic signed [V_W-1:0] V_50 = V_W'(50 * 256);
  localparam logic signed [V_W-1:0] V_90 = V_W'(90 * 256);
  localparam logic [SPD_W-1:0] SPD_STOP = SPD_W'(3);
  localparam logic [SPD_W-1:0] SPD_SLOW = SPD_W'(15);
  localparam logic [OUT_W-1:0] LAST_MIN = OUT_W'(20);

  // drive mode codes
  localparam logic [1:0] DM_STALL = 2'd1;
  localparam logic [1:0] DM_DAMP  = 2'd2;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SLOW_ACCEL   = 3'd0,
    CFG_DRIVE_MODE   = 3'd1,
    CFG_SLOW_MODE    = 3'd2,
    CFG_NORMAL       = 3'd3,
    CFG_TURN         = 3'd4,
    CFG_BOOST_NORMAL = 3'd5,
    CFG_BOOST_TURN   = 3'd6
  } cfg_idx_t;

  // stall cut choice for one wheel
  typedef struct packed {
    logic                  use_const;
    logic signed [V_W-1:0] value;
    logic [B_W-1:0]        factor;
  } cut_t;

  function automatic cut_t stall_pick(input logic signed [V_W-1:0] v,
                                      input logic [SPD_W-1:0] spd_mag,
                                      input logic [OUT_W-1:0] last_mag,
                                      input logic [B_W-1:0] mid_factor);
    cut_t c;
    c.use_const = 1'b0;
    c.value     = '0;
    c.factor    = Q_ONE;
    if (spd_mag < SPD_STOP) begin
      if (v <= V_25) begin
        c.factor = Q_ONE;
      end else if (v <= V_45) begin
        c.factor = Q_085;
      end else if (v < V_90) begin
        c.use_const = 1'b1;
        c.value     = V_45;
      end else begin
        c.use_const = 1'b1;
        c.value     = V_50;
      end
    end else if (spd_mag < SPD_SLOW && last_mag > LAST_MIN) begin
      c.factor = mid_factor;
    end
    return c;
  endfunction

  // product back to Q8 with the sign of the operand, truncated toward zero
  function automatic logic signed [V_W-1:0] q8_back(input logic neg,
                                                    input logic [P_W-1:0] p);
    logic [V_W-1:0] m;
    m = p[8 +: V_W];
    return neg ? V_W'(~m + 1'b1) : m;
  endfunction

endpackage

[rtl/arcade_drive_mixer.sv]
`timescale 1ns / 1ps

// Arcade drive mixer: forward and turn stick values plus wheel speeds in,
// left and right motor power out, one result beat per input beat.
// Input beats arrive on s_axis_*, results leave on m_axis_*; an item is
// taken when tvalid and tready are both high.
// Configuration goes through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high and registers are meant to be written while the block is idle.
// One item is worked through a sequencer of thirteen steps around a single
// shared multiplier, which computes ten products per item (two limit scalings
// with their reciprocal divides, stall cut, drive factor and slow factor for
// each wheel). The result becomes valid as the final step is left, and
// s_axis_tready returns high at that same edge; a new input beat is taken
// only once the current item is through.
// A stalled receiver holds the result in the output register; the block
// finishes the next item and then waits in its last step until the output
// register is free.
// Reset (rst, synchronous) restores the register defaults, clears the kept
// last outputs to zero and drops m_axis_tvalid.
module arcade_drive_mixer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // stick_forward[7:0], stick_turn[15:8], left_wheel_speed[26:16],
  // right_wheel_speed[37:27], zero [39:38]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_power[7:0], right_power[15:8]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ZONE, ST_FMUL, ST_FDIV, ST_TMUL, ST_TDIV, ST_MIX,
    ST_LCUT, ST_RCUT, ST_LDRV, ST_RDRV, ST_LSLOW, ST_RSLOW, ST_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic                        slow_accel_enable;
  logic [1:0]                  drive_mode;
  logic                        slow_mode;
  logic [adm_pkg::CFG_W-1:0]   fwd_limit;
  logic [adm_pkg::CFG_W-1:0]   turn_limit;
  logic [adm_pkg::CFG_W-1:0]   boost_fwd_limit;
  logic [adm_pkg::CFG_W-1:0]   boost_turn_limit;

  // captured input item
  logic signed [adm_pkg::STICK_W-1:0] in_f;
  logic signed [adm_pkg::STICK_W-1:0] in_t;
  logic signed [adm_pkg::SPD_W-1:0]   in_sl;
  logic signed [adm_pkg::SPD_W-1:0]   in_sr;

  // working values
  logic [adm_pkg::MAG_W-1:0]   vy_mag;
  logic                        vy_neg;
  logic [adm_pkg::MAG_W-1:0]   tu_mag;
  logic                        tu_neg;
  logic [adm_pkg::MAG_W-1:0]   lim_f;
  logic [adm_pkg::MAG_W-1:0]   lim_t;
  logic [adm_pkg::MAG_W-1:0]   lim_a;
  logic                        f_sc;
  logic                        t_sc;
  logic                        stall_en;
  logic signed [adm_pkg::V_W-1:0] vl;
  logic signed [adm_pkg::V_W-1:0] vr;
  logic [adm_pkg::P_W-1:0]     prod;

  // kept last outputs double as the output register
  logic signed [adm_pkg::OUT_W-1:0] last_left;
  logic signed [adm_pkg::OUT_W-1:0] last_right;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = {last_right, last_left};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_accel_enable <= 1'b0;
      drive_mode        <= 2'd0;
      slow_mode         <= 1'b0;
      fwd_limit         <= adm_pkg::CFG_W'(100);
      turn_limit        <= adm_pkg::CFG_W'(90);
      boost_fwd_limit   <= adm_pkg::CFG_W'(125);
      boost_turn_limit  <= adm_pkg::CFG_W'(120);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        adm_pkg::CFG_SLOW_ACCEL:   slow_accel_enable <= cfg_data[0];
        adm_pkg::CFG_DRIVE_MODE:   drive_mode        <= cfg_data[1:0];
        adm_pkg::CFG_SLOW_MODE:    slow_mode         <= cfg_data[0];
        adm_pkg::CFG_NORMAL:       fwd_limit         <= cfg_data;
        adm_pkg::CFG_TURN:         turn_limit        <= cfg_data;
        adm_pkg::CFG_BOOST_NORMAL: boost_fwd_limit   <= cfg_data;
        adm_pkg::CFG_BOOST_TURN:   boost_turn_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // zone selection and deadband
  logic [adm_pkg::MAG_W-1:0] af, at;
  logic [adm_pkg::MAG_W-1:0] np_w, tp_w, bn_w, bt_w, fs_w;
  logic [adm_pkg::MAG_W-1:0] z_vy, z_tu, z_lf, z_lt, z_la;
  logic [adm_pkg::MAG_W-1:0] db_vy, db_tu;
  logic f_big, f_small, t_big, t_small;

  always_comb begin
    af = in_f[adm_pkg::STICK_W-1] ? adm_pkg::MAG_W'(~in_f + 1'b1) : adm_pkg::MAG_W'(in_f);
    at = in_t[adm_pkg::STICK_W-1] ? adm_pkg::MAG_W'(~in_t + 1'b1) : adm_pkg::MAG_W'(in_t);
    np_w = adm_pkg::MAG_W'(fwd_limit);
    tp_w = adm_pkg::MAG_W'(turn_limit);
    bn_w = adm_pkg::MAG_W'(boost_fwd_limit);
    bt_w = adm_pkg::MAG_W'(boost_turn_limit);
    fs_w = adm_pkg::MAG_W'(adm_pkg::FULL_SCALE);
    f_big   = af > adm_pkg::ZONE_HI;
    f_small = af < adm_pkg::ZONE_HI;
    t_big   = at > adm_pkg::ZONE_HI;
    t_small = at < adm_pkg::ZONE_HI;
    z_vy = af;
    z_tu = at;
    z_lf = np_w;
    z_lt = tp_w;
    z_la = np_w;
    priority if (t_big && f_small) begin
      z_tu = bt_w;
      z_lt = fs_w;
      z_la = bn_w;
    end else if (t_small && f_big) begin
      z_vy = bn_w;
      z_lf = fs_w;
      z_la = bn_w;
    end else if (t_big && f_big) begin
      z_lf = bn_w;
      z_lt = bt_w;
      z_la = bn_w;
    end else if (af > adm_pkg::ZONE_LO && af <= adm_pkg::ZONE_HI && t_small) begin
      z_vy = np_w;
      z_lf = fs_w;
    end else if (at > adm_pkg::ZONE_LO && at <= adm_pkg::ZONE_HI && f_small) begin
      z_tu = tp_w;
      z_lt = fs_w;
    end else begin
      z_la = np_w;
    end
    db_vy = (z_vy <= adm_pkg::DEADBAND) ? '0 : z_vy;
    db_tu = (z_tu <= adm_pkg::DEADBAND) ? '0 : z_tu;
  end

  // scaled value out of the reciprocal product
  logic [adm_pkg::MAG_W-1:0] quot;
  assign quot = prod[adm_pkg::RECIP_SH +: adm_pkg::MAG_W];

  // sum and difference mixing
  logic [adm_pkg::MAG_W-1:0] tu_fin;
  logic signed [9:0]  vy_s, tu_s;
  logic signed [10:0] vl_i, vr_i;
  logic               mix_stall;

  always_comb begin
    tu_fin = t_sc ? quot : tu_mag;
    vy_s = vy_neg ? -signed'({2'b00, vy_mag}) : signed'({2'b00, vy_mag});
    tu_s = tu_neg ? -signed'({2'b00, tu_fin}) : signed'({2'b00, tu_fin});
    vl_i = 11'(vy_s) + 11'(tu_s);
    vr_i = 11'(vy_s) - 11'(tu_s);
    mix_stall = slow_accel_enable && (drive_mode == adm_pkg::DM_STALL) &&
                (tu_fin <= adm_pkg::STALL_TURN_MAX) &&
                (((vl_i < 0) != (vr_i < 0)) || ((vl_i == 0) != (vr_i == 0)));
  end

  // magnitudes of the power words, speeds and last outputs, clamps and stall cut picks
  logic [adm_pkg::V_W-1:0]   vl_negv, vr_negv;
  logic [adm_pkg::A_W-1:0]   vl_mag, vr_mag;
  logic [adm_pkg::A_W-1:0]   lim256;
  logic [adm_pkg::A_W-1:0]   vl_clamp, vr_clamp;
  logic [adm_pkg::SPD_W-1:0] sl_mag, sr_mag;
  logic [adm_pkg::OUT_W-1:0] ll_mag, lr_mag;
  adm_pkg::cut_t             l_pick, r_pick;

  always_comb begin
    vl_negv = -vl;
    vr_negv = -vr;
    vl_mag = vl[adm_pkg::V_W-1] ? vl_negv[adm_pkg::A_W-1:0] : vl[adm_pkg::A_W-1:0];
    vr_mag = vr[adm_pkg::V_W-1] ? vr_negv[adm_pkg::A_W-1:0] : vr[adm_pkg::A_W-1:0];
    lim256 = adm_pkg::A_W'({lim_a, 8'h00});
    vl_clamp = (vl_mag >= lim256) ? lim256 : vl_mag;
    vr_clamp = (vr_mag >= lim256) ? lim256 : vr_mag;
    sl_mag = in_sl[adm_pkg::SPD_W-1] ? adm_pkg::SPD_W'(~in_sl + 1'b1) : adm_pkg::SPD_W'(in_sl);
    sr_mag = in_sr[adm_pkg::SPD_W-1] ? adm_pkg::SPD_W'(~in_sr + 1'b1) : adm_pkg::SPD_W'(in_sr);
    ll_mag = last_left[adm_pkg::OUT_W-1] ? adm_pkg::OUT_W'(~last_left + 1'b1)
                                         : adm_pkg::OUT_W'(last_left);
    lr_mag = last_right[adm_pkg::OUT_W-1] ? adm_pkg::OUT_W'(~last_right + 1'b1)
                                          : adm_pkg::OUT_W'(last_right);
    l_pick = adm_pkg::stall_pick(vl, sl_mag, ll_mag, adm_pkg::Q_090);
    r_pick = adm_pkg::stall_pick(vr, sr_mag, lr_mag, adm_pkg::Q_095);
  end

  // shared multiplier operand select
  logic                    mul_en;
  logic [adm_pkg::A_W-1:0] mul_a;
  logic [adm_pkg::B_W-1:0] mul_b;
  logic [adm_pkg::B_W-1:0] drv_q, slow_q;

  always_comb begin
    drv_q  = (drive_mode == adm_pkg::DM_DAMP) ? adm_pkg::Q_080 : adm_pkg::Q_ONE;
    slow_q = slow_mode ? adm_pkg::Q_070 : adm_pkg::Q_ONE;
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      ST_FMUL: begin
        mul_a = adm_pkg::A_W'(vy_mag);
        mul_b = adm_pkg::B_W'(lim_f);
      end
      ST_FDIV, ST_TDIV: begin
        mul_a = adm_pkg::A_W'(prod[15:0]);
        mul_b = adm_pkg::RECIP;
      end
      ST_TMUL: begin
        mul_a = adm_pkg::A_W'(tu_mag);
        mul_b = adm_pkg::B_W'(lim_t);
      end
      ST_LCUT: begin
        mul_a = vl_mag;
        mul_b = stall_en ? l_pick.factor : adm_pkg::Q_ONE;
      end
      ST_RCUT: begin
        mul_a = vr_mag;
        mul_b = stall_en ? r_pick.factor : adm_pkg::Q_ONE;
      end
      ST_LDRV: begin
        mul_a = vl_clamp;
        mul_b = drv_q;
      end
      ST_RDRV: begin
        mul_a = vr_clamp;
        mul_b = drv_q;
      end
      ST_LSLOW: begin
        mul_a = vl_mag;
        mul_b = slow_q;
      end
      ST_RSLOW: begin
        mul_a = vr_mag;
        mul_b = slow_q;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // final powers: right straight from the last product, left from the left power word
  logic [adm_pkg::OUT_W-1:0] rp_mag, lp_mag;
  logic signed [adm_pkg::OUT_W-1:0] rp_fin, lp_fin;

  always_comb begin
    rp_mag = prod[16 +: adm_pkg::OUT_W];
    lp_mag = vl_mag[8 +: adm_pkg::OUT_W];
    rp_fin = vr[adm_pkg::V_W-1] ? adm_pkg::OUT_W'(~rp_mag + 1'b1) : rp_mag;
    lp_fin = vl[adm_pkg::V_W-1] ? adm_pkg::OUT_W'(~lp_mag + 1'b1) : lp_mag;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      last_left     <= '0;
      last_right    <= '0;
    end else begin
      // result valid set by the final step, cleared once taken
      if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            in_f  <= s_axis_tdata[7:0];
            in_t  <= s_axis_tdata[15:8];
            in_sl <= s_axis_tdata[26:16];
            in_sr <= s_axis_tdata[37:27];
            state <= ST_ZONE;
          end
        end
        ST_ZONE: begin
          vy_mag <= db_vy;
          vy_neg <= in_f[adm_pkg::STICK_W-1];
          tu_mag <= db_tu;
          tu_neg <= in_t[adm_pkg::STICK_W-1];
          lim_f  <= z_lf;
          lim_t  <= z_lt;
          lim_a  <= z_la;
          f_sc   <= db_vy < z_lf;
          t_sc   <= db_tu < z_lt;
          state  <= ST_FMUL;
        end
        ST_FMUL: state <= ST_FDIV;
        ST_FDIV: state <= ST_TMUL;
        ST_TMUL: begin
          if (f_sc) begin
            vy_mag <= quot;
          end
          state <= ST_TDIV;
        end
        ST_TDIV: state <= ST_MIX;
        ST_MIX: begin
          vl       <= adm_pkg::V_W'(signed'({vl_i, 8'h00}));
          vr       <= adm_pkg::V_W'(signed'({vr_i, 8'h00}));
          stall_en <= mix_stall;
          state    <= ST_LCUT;
        end
        ST_LCUT: state <= ST_RCUT;
        ST_RCUT: begin
          // vl, speed and last output unchanged since the mix step
          vl <= (stall_en && l_pick.use_const) ? l_pick.value
                : adm_pkg::q8_back(vl[adm_pkg::V_W-1], prod);
          state <= ST_LDRV;
        end
        ST_LDRV: begin
          vr <= (stall_en && r_pick.use_const) ? r_pick.value
                : adm_pkg::q8_back(vr[adm_pkg::V_W-1], prod);
          state <= ST_RDRV;
        end
        ST_RDRV: begin
          vl    <= adm_pkg::q8_back(vl[adm_pkg::V_W-1], prod);
          state <= ST_LSLOW;
        end
        ST_LSLOW: begin
          vr    <= adm_pkg::q8_back(vr[adm_pkg::V_W-1], prod);
          state <= ST_RSLOW;
        end
        ST_RSLOW: begin
          vl    <= adm_pkg::q8_back(vl[adm_pkg::V_W-1], prod);
          state <= ST_DONE;
        end
        ST_DONE: begin
          // commit once the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            last_left  <= lp_fin;
            last_right <= rp_fin;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a taken beat starts the sequence and drops ready
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == ST_ZONE && !s_axis_tready)
    else $error("accepted beat did not start the sequence");

  // a result only appears out of the final step
  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_DONE)
    else $error("result valid raised outside the final step");

  // clamped and scaled powers never reach the negative extreme
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:0] != 8'h80 && m_axis_tdata[15:8] != 8'h80)
    else $error("output power out of range");

  // forward scaling never exceeds its limit
  a_scale_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_TMUL && f_sc |-> quot <= lim_f)
    else $error("scaled forward value above its limit");

  // stall shaping only when enabled in stall drive mode
  a_stall_mode: assert property (@(posedge clk) disable iff (rst)
    state == ST_LCUT && stall_en |-> slow_accel_enable && drive_mode == adm_pkg::DM_STALL)
    else $error("stall shaping active outside its mode");
`endif

endmodule

[bench/arcade_drive_mixer_test.sv]
`timescale 1ns / 1ps

module arcade_drive_mixer_test;

  // mixer thresholds, and factors in Q8 with 8 fraction bits
  localparam int DEAD_ZONE    = 20;
  localparam int ZONE_HIGH    = 123;
  localparam int ZONE_LOW     = 110;
  localparam int STALL_SPREAD = 25;
  localparam int SPEED_STOP   = 3;
  localparam int SPEED_CRAWL  = 15;
  localparam int LAST_FLOOR   = 20;
  localparam int F_085 = 218;
  localparam int F_090 = 230;
  localparam int F_095 = 243;
  localparam int F_080 = 205;
  localparam int F_070 = 179;
  // index past the register list, writes there are dropped
  localparam logic [2:0] CFG_SPARE = 3'd7;
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_ITEMS   = 150;

  typedef struct {
    logic signed [7:0]  fwd;
    logic signed [7:0]  turn;
    logic signed [10:0] spd_l;
    logic signed [10:0] spd_r;
  } drive_cmd_t;

  typedef struct {
    logic signed [7:0] left;
    logic signed [7:0] right;
  } wheel_power_t;

  typedef struct {
    logic [2:0] idx;
    logic [6:0] val;
  } reg_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  arcade_drive_mixer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // register mirror and kept outputs
  logic       stall_en_q;
  logic [1:0] mode_q;
  logic       slow_q;
  int         lim_normal, lim_turn, lim_boost_fwd, lim_boost_turn;
  int         last_left, last_right;

  drive_cmd_t   cmd_backlog[$];
  reg_write_t   reg_backlog[$];
  wheel_power_t power_due[$];
  drive_cmd_t   cmd_on_bus;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int items_queued = 0;
  int results_seen = 0;
  int reg_queued = 0;
  int reg_done = 0;
  int settings_run = 0;
  int errors = 0;

  function automatic int mag(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int sgn_of(input int v);
    return v > 0 ? 1 : (v < 0 ? -1 : 0);
  endfunction

  // Q8 times Q8 factor, truncated toward zero
  function automatic int q8_mul(input int v, input int factor);
    int r;
    r = (mag(v) * factor) / 256;
    return v < 0 ? -r : r;
  endfunction

  // deadband, then scale by lim/full scale when below the limit
  function automatic int limit_shape(input int v, input int lim);
    int x;
    x = v;
    if (mag(x) <= DEAD_ZONE) x = 0;
    if (mag(x) < lim) x = (x * lim) / adm_pkg::FULL_SCALE;
    return x;
  endfunction

  // speed-down of one wheel when it is stalled or crawling
  function automatic int stall_trim(input int v, input int spd, input int last,
                                    input int factor);
    if (mag(spd) < SPEED_STOP) begin
      if (v <= 25 * 256) return v;
      if (v <= 45 * 256) return q8_mul(v, F_085);
      if (v < 90 * 256) return 45 * 256;
      return 50 * 256;
    end
    if (mag(spd) < SPEED_CRAWL && mag(last) > LAST_FLOOR) return q8_mul(v, factor);
    return v;
  endfunction

  // clamp to the overall limit, mode factors, back to whole power
  function automatic int power_out(input int v, input int lim);
    int x;
    x = v;
    if (mag(x) >= lim * 256) x = sgn_of(x) * lim * 256;
    if (mode_q == adm_pkg::DM_DAMP) x = q8_mul(x, F_080);
    if (slow_q) x = q8_mul(x, F_070);
    return x < 0 ? -((-x) / 256) : x / 256;
  endfunction

  // expected wheel powers for one stick beat, updates the kept outputs
  function automatic wheel_power_t mix_drive(input drive_cmd_t c);
    int f, t, af, at, vy, tu, lf, lt, la, vl, vr, ol, orr;
    wheel_power_t p;
    f = c.fwd;
    t = c.turn;
    af = mag(f);
    at = mag(t);
    vy = f;
    tu = t;
    lf = lim_normal;
    lt = lim_turn;
    la = lim_normal;
    // zone choice, first match wins
    if (at > ZONE_HIGH && af < ZONE_HIGH) begin
      tu = lim_boost_turn * sgn_of(t);
      lf = lim_normal; lt = adm_pkg::FULL_SCALE; la = lim_boost_fwd;
    end else if (at < ZONE_HIGH && af > ZONE_HIGH) begin
      vy = lim_boost_fwd * sgn_of(f);
      lf = adm_pkg::FULL_SCALE; lt = lim_turn; la = lim_boost_fwd;
    end else if (at > ZONE_HIGH && af > ZONE_HIGH) begin
      lf = lim_boost_fwd; lt = lim_boost_turn; la = lim_boost_fwd;
    end else if (af > ZONE_LOW && af <= ZONE_HIGH && at < ZONE_HIGH) begin
      vy = lim_normal * sgn_of(f);
      lf = adm_pkg::FULL_SCALE; lt = lim_turn; la = lim_normal;
    end else if (at > ZONE_LOW && at <= ZONE_HIGH && af < ZONE_HIGH) begin
      tu = lim_turn * sgn_of(t);
      lf = lim_normal; lt = adm_pkg::FULL_SCALE; la = lim_normal;
    end
    vy = limit_shape(vy, lf);
    tu = limit_shape(tu, lt);
    vl = (vy + tu) * 256;
    vr = (vy - tu) * 256;
    // stall speed-down
    if (stall_en_q && mode_q == adm_pkg::DM_STALL && mag(vl - vr) < STALL_SPREAD * 256 &&
        sgn_of(vl) != sgn_of(vr)) begin
      vl = stall_trim(vl, c.spd_l, last_left, F_090);
      vr = stall_trim(vr, c.spd_r, last_right, F_095);
    end
    ol = power_out(vl, la);
    orr = power_out(vr, la);
    last_left = ol;
    last_right = orr;
    p.left = 8'(ol);
    p.right = 8'(orr);
    return p;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [6:0] val);
    case (idx)
      adm_pkg::CFG_SLOW_ACCEL:   stall_en_q = val[0];
      adm_pkg::CFG_DRIVE_MODE:   mode_q = val[1:0];
      adm_pkg::CFG_SLOW_MODE:    slow_q = val[0];
      adm_pkg::CFG_NORMAL:       lim_normal = val;
      adm_pkg::CFG_TURN:         lim_turn = val;
      adm_pkg::CFG_BOOST_NORMAL: lim_boost_fwd = val;
      adm_pkg::CFG_BOOST_TURN:   lim_boost_turn = val;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // register write channel
  always @(posedge clk) begin
    reg_write_t w;
    if (rst) begin
      cfg_valid <= 1'b0;
      stall_en_q = 1'b0;
      mode_q = '0;
      slow_q = 1'b0;
      lim_normal = 100;
      lim_turn = 90;
      lim_boost_fwd = 125;
      lim_boost_turn = 120;
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        reg_done++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_backlog.size() > 0) begin
          w = reg_backlog.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.idx;
          cfg_data <= w.val;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // stick beat driver
  always @(posedge clk) begin
    drive_cmd_t c;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      last_left = 0;
      last_right = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) power_due.push_back(mix_drive(cmd_on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_backlog.size() > 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          c = cmd_backlog.pop_front();
          cmd_on_bus = c;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, c.spd_r, c.spd_l, c.turn, c.fwd};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // power beat monitor
  always @(posedge clk) begin
    wheel_power_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (power_due.size() == 0) begin
          report_mismatch($sformatf("power beat %h with none expected", m_axis_tdata));
        end else begin
          e = power_due.pop_front();
          results_seen++;
          if ($signed(m_axis_tdata[7:0]) != e.left)
            report_mismatch($sformatf("left power %0d, expected %0d (beat %0d)",
                                      $signed(m_axis_tdata[7:0]), e.left, results_seen));
          if ($signed(m_axis_tdata[15:8]) != e.right)
            report_mismatch($sformatf("right power %0d, expected %0d (beat %0d)",
                                      $signed(m_axis_tdata[15:8]), e.right, results_seen));
        end
      end
      m_axis_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  task automatic feed(input int f, input int t, input int l, input int r);
    drive_cmd_t c;
    c.fwd = 8'(f);
    c.turn = 8'(t);
    c.spd_l = 11'(l);
    c.spd_r = 11'(r);
    cmd_backlog.push_back(c);
    items_queued++;
  endtask

  task automatic set_reg(input logic [2:0] idx, input int val);
    reg_write_t w;
    w.idx = idx;
    w.val = 7'(val);
    reg_backlog.push_back(w);
    reg_queued++;
  endtask

  // wait until every write and every power beat is through
  task automatic settle();
    while (results_seen != items_queued || reg_done != reg_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int rand_stick();
    int m;
    case ($urandom_range(3, 0))
      0: return $urandom_range(255, 0);
      1: begin
        m = $urandom_range(126, 106);
        return $urandom_range(1, 0) ? m : -m;
      end
      2: return int'($urandom_range(60, 0)) - 30;
      default: begin
        case ($urandom_range(3, 0))
          0: return -128;
          1: return 127;
          2: return $urandom_range(1, 0) ? ZONE_HIGH : -ZONE_HIGH;
          default: return $urandom_range(1, 0) ? ZONE_LOW : -ZONE_LOW;
        endcase
      end
    endcase
  endfunction

  function automatic int rand_speed();
    if ($urandom_range(1, 0)) return int'($urandom_range(36, 0)) - 18;
    return $urandom_range(2047, 0);
  endfunction

  // random beats, or stall-shaped ones: forward in the deadband, a light turn, slow wheels,
  // with full-forward beats in between to leave large kept outputs
  task automatic random_burst(input int n, input bit stall_shaped);
    int t;
    repeat (n) begin
      if (stall_shaped && $urandom_range(9, 0) < 6) begin
        t = $urandom_range(45, 21);
        feed(int'($urandom_range(40, 0)) - 20, $urandom_range(1, 0) ? t : -t,
             int'($urandom_range(32, 0)) - 16, int'($urandom_range(32, 0)) - 16);
      end else if (stall_shaped && $urandom_range(3, 0) == 0) begin
        feed($urandom_range(1, 0) ? 127 : -128, int'($urandom_range(40, 0)) - 20,
             rand_speed(), rand_speed());
      end else begin
        feed(rand_stick(), rand_stick(), rand_speed(), rand_speed());
      end
    end
  endtask

  task automatic random_regs();
    set_reg(adm_pkg::CFG_SLOW_ACCEL, $urandom_range(127, 0));
    set_reg(adm_pkg::CFG_DRIVE_MODE, $urandom_range(127, 0));
    set_reg(adm_pkg::CFG_SLOW_MODE, $urandom_range(127, 0));
    set_reg(adm_pkg::CFG_NORMAL, $urandom_range(127, 0));
    set_reg(adm_pkg::CFG_TURN, $urandom_range(127, 0));
    set_reg(adm_pkg::CFG_BOOST_NORMAL, $urandom_range(127, 0));
    set_reg(adm_pkg::CFG_BOOST_TURN, $urandom_range(127, 0));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset, slow receiver
    src_idle_pct = 8;
    sink_idle_pct = 87;
    settings_run++;
    feed(0, 0, 0, 0);
    feed(127, 0, 1023, -1024);
    feed(-128, 0, -1024, 1023);
    feed(0, 127, 2, -2);
    feed(0, -128, 14, -14);
    feed(127, 127, 0, 0);
    feed(-128, -128, 0, 0);
    feed(123, 0, 5, 5);
    feed(0, -123, 5, 5);
    feed(123, -123, 0, 0);
    feed(111, 0, 0, 0);
    feed(-111, 5, 0, 0);
    feed(0, 111, 0, 0);
    feed(0, -115, 0, 0);
    feed(20, 21, 0, 0);
    feed(-21, -20, 0, 0);
    feed(124, 50, 0, 0);
    feed(50, -124, 0, 0);
    feed(110, 110, 0, 0);
    random_burst(PHASE_ITEMS, 1'b0);
    settle();

    // stall speed-down with a light turn limit
    settings_run++;
    set_reg(adm_pkg::CFG_SLOW_ACCEL, 1);
    set_reg(adm_pkg::CFG_DRIVE_MODE, adm_pkg::DM_STALL);
    set_reg(adm_pkg::CFG_SLOW_MODE, 0);
    set_reg(adm_pkg::CFG_NORMAL, 10);
    set_reg(adm_pkg::CFG_TURN, 40);
    set_reg(adm_pkg::CFG_BOOST_NORMAL, 127);
    set_reg(adm_pkg::CFG_BOOST_TURN, 6);
    settle();
    feed(127, 0, 0, 0);
    feed(0, 25, 5, -5);
    feed(0, -30, 1, 0);
    feed(127, 0, 0, 0);
    feed(0, 35, 10, 10);
    feed(-128, 0, 0, 0);
    feed(0, -39, -14, 14);
    random_burst(PHASE_ITEMS, 1'b1);
    settle();

    // damped and slow outputs, all limits at the top
    settings_run++;
    set_reg(adm_pkg::CFG_SLOW_ACCEL, 0);
    set_reg(adm_pkg::CFG_DRIVE_MODE, adm_pkg::DM_DAMP);
    set_reg(adm_pkg::CFG_SLOW_MODE, 1);
    set_reg(adm_pkg::CFG_NORMAL, 127);
    set_reg(adm_pkg::CFG_TURN, 127);
    set_reg(adm_pkg::CFG_BOOST_NORMAL, 127);
    set_reg(adm_pkg::CFG_BOOST_TURN, 127);
    settle();
    random_burst(PHASE_ITEMS, 1'b0);
    settle();

    // slow sender from here, all limits at zero
    src_idle_pct = 87;
    sink_idle_pct = 8;
    settings_run++;
    set_reg(adm_pkg::CFG_SLOW_ACCEL, 1);
    set_reg(adm_pkg::CFG_DRIVE_MODE, 0);
    set_reg(adm_pkg::CFG_SLOW_MODE, 0);
    set_reg(adm_pkg::CFG_NORMAL, 0);
    set_reg(adm_pkg::CFG_TURN, 0);
    set_reg(adm_pkg::CFG_BOOST_NORMAL, 0);
    set_reg(adm_pkg::CFG_BOOST_TURN, 0);
    settle();
    random_burst(PHASE_ITEMS, 1'b0);
    settle();

    // random settings, plus a write past the register list
    settings_run++;
    random_regs();
    set_reg(CFG_SPARE, $urandom_range(127, 0));
    settle();
    random_burst(PHASE_ITEMS, 1'b0);
    settle();

    // no idling from here, stall speed-down with slow mode
    src_idle_pct = 0;
    sink_idle_pct = 0;
    settings_run++;
    set_reg(adm_pkg::CFG_SLOW_ACCEL, 1);
    set_reg(adm_pkg::CFG_DRIVE_MODE, adm_pkg::DM_STALL);
    set_reg(adm_pkg::CFG_SLOW_MODE, 1);
    set_reg(adm_pkg::CFG_NORMAL, 15);
    set_reg(adm_pkg::CFG_TURN, 45);
    set_reg(adm_pkg::CFG_BOOST_NORMAL, 127);
    set_reg(adm_pkg::CFG_BOOST_TURN, $urandom_range(12, 0));
    settle();
    random_burst(PHASE_ITEMS, 1'b1);
    settle();

    // random limits with the unused drive mode
    settings_run++;
    random_regs();
    set_reg(adm_pkg::CFG_DRIVE_MODE, 3);
    settle();
    random_burst(PHASE_ITEMS, 1'b0);
    settle();

    if (power_due.size() != 0)
      report_mismatch($sformatf("%0d power beats never arrived", power_due.size()));
    $display("ran %0d stick beats through %0d register settings, %0d power beats compared",
             items_queued, settings_run, results_seen);
    $display("stalls: slow receiver, then slow sender, then none; %0d mismatches", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
